// ----- src/pvp_pkg.sv -----
// Shared types and constants of the perspective vertex projector.
// Used by the divider pipeline, the top level and the port checker.
package pvp_pkg;

	// Configuration register indexes.
	typedef enum logic [2:0] {
		REG_CAM_X     = 3'd0,
		REG_CAM_Y     = 3'd1,
		REG_CAM_Z     = 3'd2,
		REG_COS_YAW   = 3'd3,
		REG_SIN_YAW   = 3'd4,
		REG_COS_PITCH = 3'd5,
		REG_SIN_PITCH = 3'd6,
		REG_FOCAL     = 3'd7
	} pvp_reg_t;

	localparam int CFG_W     = 16;
	localparam int FOCAL_W   = 10;
	localparam int COORD_W   = 12;
	localparam int DIFF_W    = 17;  // vertex minus camera, Q9.8
	localparam int X1_W      = 20;  // after the yaw rotation
	localparam int Y2_W      = 23;  // after the pitch rotation
	localparam int NUM_W     = 36;  // signed dividend
	localparam int QB        = 13;  // quotient bits kept; larger always saturates
	localparam int DEN_W     = 22;  // positive depth when in front
	localparam int MAG_W     = DEN_W + QB;
	localparam int NEAR_Q8   = 25;
	localparam int BEHIND    = -1000;
	localparam int DIV_NS    = QB + 2;
	localparam int LATENCY   = 4 + DIV_NS + 1;

	typedef struct packed {
		logic             neg;
		logic             ovf;
		logic [MAG_W-1:0] rem;
		logic [QB-1:0]    q;
	} pvp_lane_t;

endpackage

// ----- src/pvp_div.sv -----
// Pipelined two-lane restoring divider with a shared positive divisor.
// Depends on pvp_pkg; after sign removal and the overflow check, one quotient bit is resolved per stage.
module pvp_div import pvp_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	input  logic                    in_tag,
	input  logic signed [NUM_W-1:0] num_x,
	input  logic signed [NUM_W-1:0] num_y,
	input  logic        [DEN_W-1:0] den,
	output logic                    out_valid,
	output logic                    out_tag,
	output pvp_lane_t               out_x,
	output pvp_lane_t               out_y
);

	logic             v_s   [DIV_NS];
	logic             tag_s [DIV_NS];
	logic [DEN_W-1:0] den_s [DIV_NS];
	pvp_lane_t        x_s   [DIV_NS];
	pvp_lane_t        y_s   [DIV_NS];

	function automatic pvp_lane_t take_abs(input logic signed [NUM_W-1:0] n);
		pvp_lane_t r;
		logic [NUM_W-1:0] m;
		m = n[NUM_W-1] ? NUM_W'(-n) : NUM_W'(n);
		r.neg = n[NUM_W-1];
		r.ovf = 1'b0;
		r.rem = m[MAG_W-1:0];
		r.q   = '0;
		return r;
	endfunction

	function automatic pvp_lane_t check_ovf(input pvp_lane_t a, input logic [DEN_W-1:0] d);
		pvp_lane_t r;
		r = a;
		r.ovf = (a.rem >= {d, {QB{1'b0}}});
		return r;
	endfunction

	function automatic pvp_lane_t div_step(input pvp_lane_t a, input logic [DEN_W-1:0] d,
			input int b);
		pvp_lane_t r;
		logic [MAG_W-1:0] sh;
		r = a;
		sh = MAG_W'(d) << b;
		if (a.rem >= sh) begin
			r.rem = a.rem - sh;
			r.q[b] = 1'b1;
		end
		return r;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < DIV_NS; j++)
				v_s[j] <= 1'b0;
		end else begin
			v_s[0] <= in_valid;
			for (int j = 1; j < DIV_NS; j++)
				v_s[j] <= v_s[j-1];
		end
	end

	always_ff @(posedge clk) begin
		tag_s[0] <= in_tag;
		den_s[0] <= den;
		x_s[0]   <= take_abs(num_x);
		y_s[0]   <= take_abs(num_y);
		x_s[1]   <= check_ovf(x_s[0], den_s[0]);
		y_s[1]   <= check_ovf(y_s[0], den_s[0]);
		for (int j = 1; j < DIV_NS; j++) begin
			tag_s[j] <= tag_s[j-1];
			den_s[j] <= den_s[j-1];
		end
		for (int j = 2; j < DIV_NS; j++) begin
			x_s[j] <= div_step(x_s[j-1], den_s[j-1], QB + 1 - j);
			y_s[j] <= div_step(y_s[j-1], den_s[j-1], QB + 1 - j);
		end
	end

	assign out_valid = v_s[DIV_NS-1];
	assign out_tag   = tag_s[DIV_NS-1];
	assign out_x     = x_s[DIV_NS-1];
	assign out_y     = y_s[DIV_NS-1];

endmodule

// ----- src/perspective_vertex_projector_unit.sv -----
// Top level of the perspective vertex projector: registers, rotations, scaling.
// Depends on pvp_pkg and pvp_div.
//
// A vertex beat is taken whenever start is high; busy is always low, so a new
// vertex can enter on every clock. Each beat produces exactly one result beat,
// shown on the screen ports for one cycle with done high once it has passed
// through four arithmetic stages (camera offset, yaw rotation, pitch rotation,
// focal scaling), fifteen divider stages (sign removal, an overflow check and
// thirteen stages that resolve one quotient bit each) and one output register.
// The receiver cannot stall the block, so results must be taken as they
// appear. Configuration writes are meant for idle periods; a write during
// traffic affects beats in flight.
module perspective_vertex_projector_unit import pvp_pkg::*; #(
	parameter int SCREEN_WIDTH  = 800,
	parameter int SCREEN_HEIGHT = 600
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic signed [15:0]         vert_x,
	input  logic signed [15:0]         vert_y,
	input  logic signed [15:0]         vert_z,
	input  logic                       cfg_we,
	input  logic [2:0]                 cfg_index,
	input  logic [CFG_W-1:0]           cfg_data,
	output logic                       done,
	output logic signed [COORD_W-1:0]  screen_x,
	output logic signed [COORD_W-1:0]  screen_y,
	output logic                       in_front,
	output logic                       on_screen
);

	localparam int CX = SCREEN_WIDTH / 2;
	localparam int CY = SCREEN_HEIGHT / 2;

	// Configuration registers.
	logic signed [15:0]  cam_x_q, cam_y_q, cam_z_q;
	logic signed [15:0]  cos_yaw_q, sin_yaw_q, cos_pitch_q, sin_pitch_q;
	logic [FOCAL_W-1:0]  focal_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cam_x_q     <= 16'sd0;
			cam_y_q     <= 16'sd512;
			cam_z_q     <= -16'sd1280;
			cos_yaw_q   <= 16'sd16384;
			sin_yaw_q   <= 16'sd0;
			cos_pitch_q <= 16'sd16384;
			sin_pitch_q <= 16'sd0;
			focal_q     <= FOCAL_W'(256);
		end else if (cfg_we) begin
			unique case (pvp_reg_t'(cfg_index))
				REG_CAM_X:     cam_x_q     <= cfg_data;
				REG_CAM_Y:     cam_y_q     <= cfg_data;
				REG_CAM_Z:     cam_z_q     <= cfg_data;
				REG_COS_YAW:   cos_yaw_q   <= cfg_data;
				REG_SIN_YAW:   sin_yaw_q   <= cfg_data;
				REG_COS_PITCH: cos_pitch_q <= cfg_data;
				REG_SIN_PITCH: sin_pitch_q <= cfg_data;
				REG_FOCAL:     focal_q     <= cfg_data[FOCAL_W-1:0];
				default:       ;
			endcase
		end
	end

	assign busy = 1'b0;

	// Valid bits travel alongside the data through every stage.
	logic v_s1, v_s2, v_s3, v_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= start;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// Stage 1: offset from the camera, exact in 17 bits.
	logic signed [DIFF_W-1:0] dx_s1, dy_s1, dz_s1;

	always_ff @(posedge clk) begin
		dx_s1 <= DIFF_W'(vert_x) - DIFF_W'(cam_x_q);
		dy_s1 <= DIFF_W'(vert_y) - DIFF_W'(cam_y_q);
		dz_s1 <= DIFF_W'(vert_z) - DIFF_W'(cam_z_q);
	end

	// Stage 2: rotation by minus yaw about Y. The arithmetic shift is a floor.
	logic signed [33:0]       x1_sum, z1_sum;
	logic signed [X1_W-1:0]   x1_s2, z1_s2;
	logic signed [DIFF_W-1:0] dy_s2;

	assign x1_sum = dx_s1 * cos_yaw_q - dz_s1 * sin_yaw_q;
	assign z1_sum = dx_s1 * sin_yaw_q + dz_s1 * cos_yaw_q;

	always_ff @(posedge clk) begin
		x1_s2 <= X1_W'(x1_sum >>> 14);
		z1_s2 <= X1_W'(z1_sum >>> 14);
		dy_s2 <= dy_s1;
	end

	// Stage 3: rotation by minus pitch about X.
	logic signed [36:0]     y2_sum, z2_sum;
	logic signed [Y2_W-1:0] y2_s3, z2_s3;
	logic signed [X1_W-1:0] x1_s3;

	assign y2_sum = dy_s2 * cos_pitch_q + z1_s2 * sin_pitch_q;
	assign z2_sum = z1_s2 * cos_pitch_q - dy_s2 * sin_pitch_q;

	always_ff @(posedge clk) begin
		y2_s3 <= Y2_W'(y2_sum >>> 14);
		z2_s3 <= Y2_W'(z2_sum >>> 14);
		x1_s3 <= x1_s2;
	end

	// Stage 4: scale by the focal length and apply the near plane test.
	logic signed [FOCAL_W:0]  f_sg;
	logic signed [NUM_W-1:0]  nx_prod, ny_prod;
	logic signed [NUM_W-1:0]  nx_s4, ny_s4;
	logic [DEN_W-1:0]         den_s4;
	logic                     front_s4;

	assign f_sg    = $signed({1'b0, focal_q});
	assign nx_prod = x1_s3 * f_sg;
	assign ny_prod = y2_s3 * f_sg;

	always_ff @(posedge clk) begin
		nx_s4    <= nx_prod;
		ny_s4    <= -ny_prod;
		den_s4   <= z2_s3[DEN_W-1:0];
		front_s4 <= (z2_s3 > Y2_W'(NEAR_Q8));
	end

	// Division by depth; the quotient truncates toward zero.
	logic      dv_valid, dv_front;
	pvp_lane_t dv_x, dv_y;

	pvp_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s4),
		.in_tag    (front_s4),
		.num_x     (nx_s4),
		.num_y     (ny_s4),
		.den       (den_s4),
		.out_valid (dv_valid),
		.out_tag   (dv_front),
		.out_x     (dv_x),
		.out_y     (dv_y)
	);

	// Applies the sign, adds the screen center and saturates to 12 bits.
	// A quotient at or beyond 2^13 always saturates, whatever the center.
	function automatic logic signed [COORD_W-1:0] place(input pvp_lane_t l,
			input logic signed [15:0] center);
		logic signed [15:0] v;
		logic signed [15:0] s;
		v = l.neg ? -$signed({3'b000, l.q}) : $signed({3'b000, l.q});
		s = v + center;
		if (l.ovf)
			return l.neg ? COORD_W'(-2048) : COORD_W'(2047);
		else if (s > 16'sd2047)
			return COORD_W'(2047);
		else if (s < -16'sd2048)
			return COORD_W'(-2048);
		else
			return COORD_W'(s);
	endfunction

	logic signed [COORD_W-1:0] px, py;

	always_comb begin
		if (dv_front) begin
			px = place(dv_x, 16'(CX));
			py = place(dv_y, 16'(CY));
		end else begin
			px = COORD_W'(BEHIND);
			py = COORD_W'(BEHIND);
		end
	end

	// Output register; one result beat per cycle at most.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= dv_valid;
		end
	end

	always_ff @(posedge clk) begin
		screen_x  <= px;
		screen_y  <= py;
		in_front  <= dv_front;
		on_screen <= (px >= 0) && (px < 13'(SCREEN_WIDTH))
			&& (py >= 0) && (py < 13'(SCREEN_HEIGHT));
	end

endmodule

// ----- src/pvp_chk.sv -----
// Port-level checker for the perspective vertex projector, with its bind.
// Depends on pvp_pkg for the fixed latency.
module pvp_chk import pvp_pkg::*; (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      start,
	input logic                      busy,
	input logic                      done,
	input logic signed [COORD_W-1:0] screen_x,
	input logic signed [COORD_W-1:0] screen_y,
	input logic                      in_front,
	input logic                      on_screen
);

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##LATENCY done)
		else $error("result beat missing after fixed latency");

	a_no_extra: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LATENCY))
		else $error("result beat without a vertex beat");

	a_behind: assert property (@(posedge clk) disable iff (!arst_n)
		done && !in_front |-> screen_x == -12'sd1000 && screen_y == -12'sd1000
			&& !on_screen)
		else $error("behind-camera result is malformed");

	a_visible: assert property (@(posedge clk) disable iff (!arst_n)
		done && on_screen |-> screen_x >= 0 && screen_y >= 0 && in_front)
		else $error("on-screen flag with negative coordinate");

endmodule

bind perspective_vertex_projector_unit pvp_chk u_pvp_chk (.*);

// ----- dv/perspective_vertex_projector_unit_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench of the perspective vertex projector unit.
// Depends on pvp_pkg and the projector RTL; predicts results internally or uses hand-typed ones.
module perspective_vertex_projector_unit_tb;
	import pvp_pkg::*;

	localparam int SW = 800;
	localparam int SH = 600;
	localparam int N_RANDOM = 1700;
	localparam int CYCLE_LIMIT = 400000;

	typedef struct packed {
		logic signed [11:0] sx;
		logic signed [11:0] sy;
		logic               front;
		logic               vis;
	} proj_t;

	// One row of the directed table: the vertex and, where it is obvious,
	// the expected result typed in by hand.
	typedef struct {
		logic signed [15:0] vx, vy, vz;
		bit                 typed;
		proj_t              want;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic signed [15:0] vert_x = '0, vert_y = '0, vert_z = '0;
	logic cfg_we = 1'b0;
	logic [2:0] cfg_index = '0;
	logic [CFG_W-1:0] cfg_data = '0;
	logic done;
	logic signed [COORD_W-1:0] screen_x, screen_y;
	logic in_front, on_screen;

	// The testbench's own copy of the camera registers.
	logic signed [15:0] m_cx, m_cy, m_cz, m_cyaw, m_syaw, m_cpit, m_spit;
	logic [9:0] m_focal;

	proj_t pending_proj[$];
	int errors = 0;
	int cycles = 0;

	perspective_vertex_projector_unit #(.SCREEN_WIDTH(SW), .SCREEN_HEIGHT(SH)) i_dut (
		.clk, .arst_n, .start, .busy, .vert_x, .vert_y, .vert_z,
		.cfg_we, .cfg_index, .cfg_data, .done, .screen_x, .screen_y,
		.in_front, .on_screen
	);

	always #5 clk = ~clk;

	// Floor division by 2^14 is exactly an arithmetic shift.
	function automatic longint fl14(longint v);
		return v >>> 14;
	endfunction

	function automatic longint clip12(longint v);
		if (v > 2047) return 2047;
		if (v < -2048) return -2048;
		return v;
	endfunction

	function automatic proj_t project(logic signed [15:0] vx, logic signed [15:0] vy,
			logic signed [15:0] vz);
		longint dx, dy, dz, x1, z1, y2, z2, px, py, f;
		proj_t r;
		dx = longint'(vx) - longint'(m_cx);
		dy = longint'(vy) - longint'(m_cy);
		dz = longint'(vz) - longint'(m_cz);
		f = longint'(m_focal);
		x1 = fl14(dx * m_cyaw - dz * m_syaw);
		z1 = fl14(dx * m_syaw + dz * m_cyaw);
		y2 = fl14(dy * m_cpit + z1 * m_spit);
		z2 = fl14(z1 * m_cpit - dy * m_spit);
		r.front = z2 > NEAR_Q8;
		if (r.front) begin
			// SystemVerilog integer division truncates toward zero, as required.
			px = clip12((x1 * f) / z2 + SW / 2);
			py = clip12((-y2 * f) / z2 + SH / 2);
		end else begin
			px = BEHIND;
			py = BEHIND;
		end
		r.vis = px >= 0 && px < SW && py >= 0 && py < SH;
		r.sx = px[11:0];
		r.sy = py[11:0];
		return r;
	endfunction

	task automatic write_reg(pvp_reg_t idx, logic [15:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			REG_CAM_X:     m_cx = val;
			REG_CAM_Y:     m_cy = val;
			REG_CAM_Z:     m_cz = val;
			REG_COS_YAW:   m_cyaw = val;
			REG_SIN_YAW:   m_syaw = val;
			REG_COS_PITCH: m_cpit = val;
			REG_SIN_PITCH: m_spit = val;
			REG_FOCAL:     m_focal = val[9:0];
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Drain: wait for every expected beat, then a margin longer than the pipeline latency.
	task automatic drain();
		while (pending_proj.size() != 0) @(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	// Holds start for one accepted beat; busy is tied low but still honored.
	task automatic send_vertex(logic signed [15:0] vx, logic signed [15:0] vy,
			logic signed [15:0] vz, bit typed, proj_t want, bit gaps);
		if (gaps) begin
			while ($urandom_range(99) < 25) begin
				@(posedge clk);
				start <= 1'b0;
			end
		end
		@(posedge clk);
		start <= 1'b1;
		vert_x <= vx;
		vert_y <= vy;
		vert_z <= vz;
		pending_proj.insert(pending_proj.size(), typed ? want : project(vx, vy, vz));
		@(negedge clk);
		while (busy) @(negedge clk);
	endtask

	// The vertex beat entered on the edge after the queue insert; the pipeline keeps
	// beats in order, so queue order equals arrival order.
	always @(posedge clk) begin
		proj_t exp_p;
		if (arst_n && done) begin
			if (pending_proj.size() == 0) begin
				$error("result beat with nothing expected");
				errors++;
			end else begin
				exp_p = pending_proj.pop_front();
				if (screen_x !== exp_p.sx) begin
					$error("screen_x expected %0d actual %0d", exp_p.sx, screen_x);
					errors++;
				end
				if (screen_y !== exp_p.sy) begin
					$error("screen_y expected %0d actual %0d", exp_p.sy, screen_y);
					errors++;
				end
				if (in_front !== exp_p.front) begin
					$error("in_front expected %0d actual %0d", exp_p.front, in_front);
					errors++;
				end
				if (on_screen !== exp_p.vis) begin
					$error("on_screen expected %0d actual %0d", exp_p.vis, on_screen);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAIL perspective_vertex_projector_unit");
			$finish;
		end
	end

	function automatic logic [15:0] rand_trig();
		case ($urandom_range(3))
			0: return 16'(16384);
			1: return -16'sd16384;
			2: return 16'($urandom_range(32767)) - 16'd16384;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [15:0] rand_coord();
		case ($urandom_range(4))
			0: return 16'h7FFF;
			1: return 16'h8000;
			2: return 16'($urandom_range(4095)) - 16'd2048;
			default: return 16'($urandom);
		endcase
	endfunction

	initial begin
		row_t rows[$];
		row_t r;
		proj_t behind_p, centre_p;
		bit gaps;
		m_cx = 0; m_cy = 512; m_cz = -1280;
		m_cyaw = 16384; m_syaw = 0; m_cpit = 16384; m_spit = 0; m_focal = 256;
		behind_p = '{sx: 12'(BEHIND), sy: 12'(BEHIND), front: 1'b0, vis: 1'b0};
		centre_p = '{sx: 12'(SW / 2), sy: 12'(SH / 2), front: 1'b1, vis: 1'b1};

		// After reset the camera sits at (0,2,-5) looking down +z.
		r = '{vx: 0, vy: 512, vz: 0, typed: 1, want: centre_p}; rows.insert(rows.size(), r);
		r = '{vx: 0, vy: 512, vz: -1280, typed: 1, want: behind_p};
		rows.insert(rows.size(), r);
		r = '{vx: 0, vy: 512, vz: -1255, typed: 1, want: behind_p};
		rows.insert(rows.size(), r);
		r = '{vx: 0, vy: 512, vz: -1254, typed: 0, want: '0}; rows.insert(rows.size(), r);
		r = '{vx: 16'sh7FFF, vy: 16'sh7FFF, vz: -1200, typed: 0, want: '0};
		rows.insert(rows.size(), r);
		r = '{vx: 16'sh8000, vy: 16'sh8000, vz: -1200, typed: 0, want: '0};
		rows.insert(rows.size(), r);
		r = '{vx: 16'sh7FFF, vy: 16'sh8000, vz: 16'sh7FFF, typed: 0, want: '0};
		rows.insert(rows.size(), r);
		r = '{vx: 16'sh8000, vy: 16'sh7FFF, vz: 16'sh8000, typed: 1, want: behind_p};
		rows.insert(rows.size(), r);
		r = '{vx: 100, vy: 400, vz: 256, typed: 0, want: '0}; rows.insert(rows.size(), r);
		r = '{vx: -3000, vy: 700, vz: 0, typed: 0, want: '0}; rows.insert(rows.size(), r);
		r = '{vx: 3000, vy: 2000, vz: 0, typed: 0, want: '0}; rows.insert(rows.size(), r);
		r = '{vx: 0, vy: -16'sd512, vz: 1000, typed: 0, want: '0};
		rows.insert(rows.size(), r);
		r = '{vx: 16'hFFFF, vy: 16'hFFFF, vz: 16'hFFFF, typed: 0, want: '0};
		rows.insert(rows.size(), r);
		r = '{vx: 16'h5555, vy: 16'hAAAA, vz: 16'h5555, typed: 0, want: '0};
		rows.insert(rows.size(), r);

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[i])
			send_vertex(rows[i].vx, rows[i].vy, rows[i].vz, rows[i].typed, rows[i].want, 0);
		@(posedge clk);
		start <= 1'b0;
		drain();

		// Zero focal length pins every point in front to the screen center.
		write_reg(REG_FOCAL, 16'd0);
		send_vertex(16'sh7FFF, 0, 0, 1, centre_p, 0);
		send_vertex(-16'sd900, 16'sh7000, 100, 1, centre_p, 0);
		@(posedge clk);
		start <= 1'b0;
		drain();

		// Random phases: new camera setting each phase, extremes included.
		for (int ph = 0; ph < 10; ph++) begin
			write_reg(REG_CAM_X, ph == 1 ? 16'h7FFF : ph == 2 ? 16'h8000 : rand_coord());
			write_reg(REG_CAM_Y, ph == 1 ? 16'h8000 : ph == 2 ? 16'h7FFF : rand_coord());
			write_reg(REG_CAM_Z, ph == 1 ? 16'h8000 : ph < 5 ? -16'sd1280 : rand_coord());
			write_reg(REG_COS_YAW, ph == 0 ? 16'd16384 : rand_trig());
			write_reg(REG_SIN_YAW, ph == 0 ? 16'd0 : rand_trig());
			write_reg(REG_COS_PITCH, ph == 3 ? -16'sd16384 : rand_trig());
			write_reg(REG_SIN_PITCH, ph == 3 ? 16'd16384 : rand_trig());
			write_reg(REG_FOCAL, ph == 1 ? 16'd1023 : ph == 2 ? 16'd1 :
				16'($urandom_range(1023)));
			// Phase 4 runs back to back with no idle cycles at all.
			gaps = (ph != 4);
			for (int n = 0; n < N_RANDOM / 10; n++)
				send_vertex(rand_coord(), rand_coord(), rand_coord(), 0, '0, gaps);
			@(posedge clk);
			start <= 1'b0;
			// The sender holds off until every outstanding beat is back.
			drain();
		end

		if (errors == 0)
			$display("PASS perspective_vertex_projector_unit");
		else
			$display("FAIL perspective_vertex_projector_unit");
		$finish;
	end
endmodule

// ----- filelist.f -----
src/pvp_pkg.sv
src/pvp_div.sv
src/perspective_vertex_projector_unit.sv
src/pvp_chk.sv
dv/perspective_vertex_projector_unit_tb.sv
